/* sv/lru_key_value_cache_top_assert.svh */
// assertion macros shared by the cache rtl
`ifndef LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH

// same-cycle implication
`define LKVC_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("lkvc assertion failed");

// next-cycle implication
`define LKVC_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("lkvc assertion failed");

`endif

/* sv/lkvc_pkg.sv */
// shared types and constants for the lru key-value cache
package lkvc_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int CAP_W   = 5;
   // widest slot index over the supported entry counts
   localparam int SLOT_W  = 6;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic {
      CMD_GET = 1'b0,
      CMD_PUT = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [KEY_W-1:0]  key;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } lookup_type;

endpackage

/* sv/lkvc_tags.sv */
// key store, valid bits, recency ranks and fill count with single-pass update
module lkvc_tags #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         lookup_en,
   input  lkvc_pkg::req_type            req,
   input  logic [lkvc_pkg::CAP_W-1:0]   capacity,
   output lkvc_pkg::lookup_type         lookup
);

   localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int EW     = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

   logic [lkvc_pkg::KEY_W-1:0] key_ff [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0]     valid_ff, valid_in;
   logic [RANK_W-1:0]          rank_ff [MAX_ENTRIES];
   logic [RANK_W-1:0]          rank_in [MAX_ENTRIES];
   logic [CNT_W-1:0]           filled_ff, filled_in;

   logic [MAX_ENTRIES-1:0]     match;
   logic                       hit;
   logic [IDX_W-1:0]           hit_idx, free_idx, victim_idx, target;
   logic [RANK_W-1:0]          hit_rank, last_rank, thr;
   logic                       bump_all, evict, is_put, update, install;
   logic [EW-1:0]              cap_ext, cap_eff;

   always_comb begin
      hit_idx    = '0;
      hit_rank   = '0;
      victim_idx = '0;
      free_idx   = '0;
      last_rank  = RANK_W'(filled_ff - CNT_W'(1));
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == req.key);
         if (match[i]) begin
            hit_idx  = hit_idx | IDX_W'(i);
            hit_rank = hit_rank | rank_ff[i];
         end
         // least recent entry holds the highest rank in use
         if (valid_ff[i] && (rank_ff[i] == last_rank)) begin
            victim_idx = victim_idx | IDX_W'(i);
         end
      end
      // lowest-numbered free slot
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
      hit = |match;

      cap_ext = EW'(capacity);
      if (cap_ext == '0) begin
         cap_eff = EW'(1);
      end else if (cap_ext > EW'(MAX_ENTRIES)) begin
         cap_eff = EW'(MAX_ENTRIES);
      end else begin
         cap_eff = cap_ext;
      end
      evict = (EW'(filled_ff) >= cap_eff);

      is_put = (req.cmd == lkvc_pkg::CMD_PUT);
      if (hit) begin
         target   = hit_idx;
         thr      = hit_rank;
         bump_all = 1'b0;
      end else if (evict) begin
         target   = victim_idx;
         thr      = last_rank;
         bump_all = 1'b0;
      end else begin
         target   = free_idx;
         thr      = '0;
         bump_all = 1'b1;
      end
      update  = lookup_en && (hit || is_put);
      install = lookup_en && is_put && !hit;

      for (int i = 0; i < MAX_ENTRIES; i++) begin
         valid_in[i] = valid_ff[i];
         rank_in[i]  = rank_ff[i];
         if (update) begin
            if (IDX_W'(i) == target) begin
               rank_in[i] = '0;
               if (install) begin
                  valid_in[i] = 1'b1;
               end
            end else if (valid_ff[i] && (bump_all || (rank_ff[i] < thr))) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end
      end
      filled_in = (install && !evict) ? filled_ff + CNT_W'(1) : filled_ff;

      lookup.hit  = hit;
      lookup.slot = lkvc_pkg::SLOT_W'(target);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         filled_ff <= '0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff  <= valid_in;
         filled_ff <= filled_in;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (install) begin
         key_ff[target] <= req.key;
      end
   end

endmodule

/* sv/lru_key_value_cache_top.sv */
// lru key-value cache top level: handshakes, capacity register, value memory
//
//   channel | dir | beat contents
//   req_    | in  | tdata = key, value; tuser = cmd
//   rsp_    | out | tdata = read_value; tuser = found (gets only)
//   csr_    | in  | data = capacity_in_use
//
// one request per cycle sustained, get or put in any mix, except while a get waits on a full response register
// a get's response is registered after its beat: the input register feeds
// one pass of parallel key compare and rank update that writes the result register
// puts give no response and never wait on the response side
// a get waits in the input register while the response register is full
// reset clears valid bits, ranks and fill count at once; capacity resets to 16
module lru_key_value_cache_top #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [63:0]                   req_tdata,   // key[31:0], value[63:32]
   input  logic [0:0]                    req_tuser,   // cmd[0]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,   // read_value[31:0]
   output logic [0:0]                    rsp_tuser,   // found[0]
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lkvc_pkg::CAP_W-1:0]    csr_data
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   logic [lkvc_pkg::CAP_W-1:0]   capacity_ff;
   logic                         in_valid_ff, in_valid_in;
   lkvc_pkg::req_type            in_req_ff;
   logic [lkvc_pkg::VALUE_W-1:0] in_value_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         found_ff;
   logic [lkvc_pkg::VALUE_W-1:0] read_ff;
   logic [lkvc_pkg::VALUE_W-1:0] value_mem [MAX_ENTRIES];

   lkvc_pkg::lookup_type         lookup;
   logic                         is_get, rsp_free, advance, req_beat;

   assign csr_ready = 1'b1;

   assign is_get     = (in_req_ff.cmd == lkvc_pkg::CMD_GET);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!is_get || rsp_free);
   assign req_tready = !in_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = req_beat ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      if (advance && is_get) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= lkvc_pkg::CAP_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_req_ff.cmd <= lkvc_pkg::cmd_type'(req_tuser[0]);
         in_req_ff.key <= req_tdata[31:0];
         in_value_ff   <= req_tdata[63:32];
      end
   end

   lkvc_tags #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_tags (
      .clock     (clock),
      .reset     (reset),
      .lookup_en (advance),
      .req       (in_req_ff),
      .capacity  (capacity_ff),
      .lookup    (lookup)
   );

   // every put lands in its slot: hit, victim or free
   always_ff @(posedge clock) begin
      if (advance && !is_get) begin
         value_mem[lookup.slot[IDX_W-1:0]] <= in_value_ff;
      end
      if (advance && is_get) begin
         read_ff  <= value_mem[lookup.slot[IDX_W-1:0]];
         found_ff <= lookup.hit;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = found_ff ? read_ff : '1;
   assign rsp_tuser[0] = found_ff;

`include "lru_key_value_cache_top_assert.svh"

   `LKVC_ASSERT_NEXT(a_no_spurious_rsp, clock, reset, !rsp_valid_ff && !(advance && is_get), !rsp_valid_ff)
   `LKVC_ASSERT_NOW(a_get_blocks_req, clock, reset, in_valid_ff && is_get && rsp_valid_ff && !rsp_tready, !req_tready)
   `LKVC_ASSERT_NEXT(a_held_item_kept, clock, reset, in_valid_ff && !advance, in_valid_ff)

endmodule
